// ===== hdl/gmlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmlp_pkg
// Types and constants shared by the M-code line parser modules.
// ----------------------------------------------------------------------------
package gmlp_pkg;

	localparam int CodeW   = 16;
	localparam int StatusW = 3;
	localparam int OutW    = 24;

	// result status codes
	localparam logic [StatusW-1:0] ST_OK        = 3'd0;
	localparam logic [StatusW-1:0] ST_NO_CODE   = 3'd1;
	localparam logic [StatusW-1:0] ST_G_UNSUP   = 3'd2;
	localparam logic [StatusW-1:0] ST_M_UNSUP   = 3'd3;
	localparam logic [StatusW-1:0] ST_S_MISSING = 3'd4;
	localparam logic [StatusW-1:0] ST_P_MISSING = 3'd5;

	// characters
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// recognized codes
	localparam logic [CodeW-1:0] CODE_ECHO  = 16'd111;
	localparam logic [CodeW-1:0] CODE_LIGHT = 16'd355;

	typedef enum logic [8:0] {
		PH_LEAD      = 9'b000000001,
		PH_DIGITS    = 9'b000000010,
		PH_ECHO_SPC  = 9'b000000100,
		PH_ECHO_VAL  = 9'b000001000,
		PH_LIGHT_SPC = 9'b000010000,
		PH_LIGHT_VAL = 9'b000100000,
		PH_LIGHT_NUM = 9'b001000000,
		PH_LIGHT_GAP = 9'b010000000,
		PH_DONE      = 9'b100000000
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [CodeW-1:0]     code_accum;
		logic                 switch_pending;
		logic [StatusW-1:0]   decided_status;
		logic                 echo_flag;
		logic                 light_flag;
	} line_state_t;

endpackage
`default_nettype wire

// ===== hdl/gmlp_char_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmlp_char_step
// Next-state logic of the line parser for one character, including the
// phases that hand the same character on to the following phase.
// ----------------------------------------------------------------------------
module gmlp_char_step (
	input  wire gmlp_pkg::line_state_t cur,
	input  wire logic [7:0]            ch,
	input  wire logic                  light_command_enabled,
	output gmlp_pkg::line_state_t      nxt
);

	logic                          is_digit;
	logic                          is_space;
	logic [gmlp_pkg::CodeW-1:0]    digit_val;
	gmlp_pkg::phase_t              ph;

	assign is_digit  = (ch >= gmlp_pkg::CH_ZERO) && (ch <= gmlp_pkg::CH_NINE);
	assign is_space  = (ch == gmlp_pkg::CH_SPACE);
	assign digit_val = {{(gmlp_pkg::CodeW-4){1'b0}}, ch[3:0]};

	always_comb begin
		nxt = cur;
		ph  = cur.phase;

		// phases that pass the character on before it is consumed
		if (ph == gmlp_pkg::PH_DIGITS && !is_digit) begin
			if (cur.code_accum == gmlp_pkg::CODE_ECHO) begin
				ph = gmlp_pkg::PH_ECHO_SPC;
			end else if (cur.code_accum == gmlp_pkg::CODE_LIGHT && light_command_enabled) begin
				ph = gmlp_pkg::PH_LIGHT_SPC;
			end
		end
		if (ph == gmlp_pkg::PH_LIGHT_VAL) begin
			nxt.switch_pending = (ch == gmlp_pkg::CH_ONE);
			ph = gmlp_pkg::PH_LIGHT_NUM;
		end
		if (ph == gmlp_pkg::PH_LIGHT_NUM && !is_digit) begin
			ph = gmlp_pkg::PH_LIGHT_GAP;
		end

		nxt.phase = ph;
		case (ph)
			gmlp_pkg::PH_LEAD: begin
				if (ch == gmlp_pkg::CH_M) begin
					nxt.phase = gmlp_pkg::PH_DIGITS;
				end else if (ch == gmlp_pkg::CH_G) begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_G_UNSUP;
				end else if (!is_space) begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_NO_CODE;
				end
			end
			gmlp_pkg::PH_DIGITS: begin
				if (is_digit) begin
					// accum * 10 + digit, wraps at 16 bits
					nxt.code_accum = (cur.code_accum << 3) + (cur.code_accum << 1) + digit_val;
				end else begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_M_UNSUP;
				end
			end
			gmlp_pkg::PH_ECHO_SPC: begin
				if (ch == gmlp_pkg::CH_S) begin
					nxt.phase = gmlp_pkg::PH_ECHO_VAL;
				end else if (!is_space) begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_S_MISSING;
				end
			end
			gmlp_pkg::PH_ECHO_VAL: begin
				nxt.echo_flag      = (ch == gmlp_pkg::CH_ONE);
				nxt.phase          = gmlp_pkg::PH_DONE;
				nxt.decided_status = gmlp_pkg::ST_OK;
			end
			gmlp_pkg::PH_LIGHT_SPC: begin
				if (ch == gmlp_pkg::CH_S) begin
					nxt.phase = gmlp_pkg::PH_LIGHT_VAL;
				end else if (!is_space) begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_S_MISSING;
				end
			end
			gmlp_pkg::PH_LIGHT_NUM: begin
				nxt.phase = gmlp_pkg::PH_LIGHT_NUM;
			end
			gmlp_pkg::PH_LIGHT_GAP: begin
				if (ch == gmlp_pkg::CH_P) begin
					nxt.light_flag     = nxt.switch_pending;
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_OK;
				end else if (!is_space) begin
					nxt.phase          = gmlp_pkg::PH_DONE;
					nxt.decided_status = gmlp_pkg::ST_P_MISSING;
				end
			end
			gmlp_pkg::PH_DONE: begin
				nxt.phase = gmlp_pkg::PH_DONE;
			end
			default: begin
				nxt.phase = gmlp_pkg::PH_DONE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/gcode_mcode_line_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_mcode_line_parser_unit
// Parses an M-code command line one character per item and reports one
// status item per line (echo and case light commands handled).
// ----------------------------------------------------------------------------
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: ch, tlast: last
// m_axis   | out | m_axis_tvalid/tready   | tdata: status, mcode, echo_on, light_on
// cfg      | in  | cfg_valid/cfg_ready    | cfg_data: light_command_enabled
//
// One character item is taken per cycle unless a held result stalls the input;
// the parser state updates in the same cycle and a line result is in the
// output register in the cycle after its last character. The output register
// is one deep: a new item is taken while the held result is taken or absent.
// Reset: line state, echo/light flags cleared, light command enabled.
// ----------------------------------------------------------------------------
module gcode_mcode_line_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // last
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata,   // [2:0] status, [18:3] mcode,
	                                         // [19] echo_on, [20] light_on
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic        cfg_data        // light_command_enabled
);

	gmlp_pkg::line_state_t               line_q;
	gmlp_pkg::line_state_t               step_char;
	gmlp_pkg::line_state_t               step_eol;
	gmlp_pkg::line_state_t               line_end;
	logic                                light_en_q;
	logic                                out_valid_q;
	logic [gmlp_pkg::OutW-1:0]           out_data_q;
	logic                                in_fire;
	logic [gmlp_pkg::CodeW-1:0]          res_code;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	gmlp_char_step u_step_char (
		.cur                   (line_q),
		.ch                    (s_axis_tdata),
		.light_command_enabled (light_en_q),
		.nxt                   (step_char)
	);

	// line end acts as one more character that matches nothing
	gmlp_char_step u_step_eol (
		.cur                   (step_char),
		.ch                    (gmlp_pkg::CH_NUL),
		.light_command_enabled (light_en_q),
		.nxt                   (step_eol)
	);

	assign line_end = (step_char.phase == gmlp_pkg::PH_DONE) ? step_char : step_eol;
	assign res_code = (line_end.decided_status == gmlp_pkg::ST_NO_CODE ||
	                   line_end.decided_status == gmlp_pkg::ST_G_UNSUP)
	                  ? '0 : line_end.code_accum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			light_en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q.phase          <= gmlp_pkg::PH_LEAD;
			line_q.code_accum     <= '0;
			line_q.switch_pending <= 1'b0;
			line_q.decided_status <= gmlp_pkg::ST_OK;
			line_q.echo_flag      <= 1'b0;
			line_q.light_flag     <= 1'b0;
		end else if (in_fire) begin
			if (s_axis_tlast) begin
				line_q.phase          <= gmlp_pkg::PH_LEAD;
				line_q.code_accum     <= '0;
				line_q.switch_pending <= 1'b0;
				line_q.decided_status <= gmlp_pkg::ST_OK;
				line_q.echo_flag      <= line_end.echo_flag;
				line_q.light_flag     <= line_end.light_flag;
			end else begin
				line_q <= step_char;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_axis_tlast) begin
			out_data_q <= {3'b000, line_end.light_flag, line_end.echo_flag,
			               res_code, line_end.decided_status};
		end
	end

	// a last character always leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tlast) |=> m_axis_tvalid)
		else $error("no result after last character");

	// every line starts fresh
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tlast) |=>
		(line_q.phase == gmlp_pkg::PH_LEAD && line_q.code_accum == '0))
		else $error("line state not cleared after line end");

	// status stays within its defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= gmlp_pkg::ST_P_MISSING))
		else $error("undefined status code");

	// lines without an M code report code zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[2:0] == gmlp_pkg::ST_NO_CODE ||
		                   m_axis_tdata[2:0] == gmlp_pkg::ST_G_UNSUP))
		|-> (m_axis_tdata[18:3] == '0))
		else $error("nonzero code without M command");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the M-code line parser: feeds command lines one
// character item at a time, predicts each line status in a local parser
// model and checks every output item, under random source gaps, sink stalls,
// one long sink hold-off and changes of the light command enable.
// ----------------------------------------------------------------------------
module tb_top;
	import gmlp_pkg::*;

	localparam int LIMIT        = 400000;
	localparam int HOLD_AT      = 1200;
	localparam int HOLD_LEN     = 400;
	localparam int RANDOM_ITEMS = 1750;
	localparam int SETTLE       = 4;
	// '_' in a directed line stands for a zero byte (strings cannot hold one)
	localparam logic [7:0] NUL_MARK = "_";

	typedef struct packed {
		logic               light_on;
		logic               echo_on;
		logic [CodeW-1:0]   mcode;
		logic [StatusW-1:0] status;
	} line_result_t;

	typedef struct {
		string        text;
		logic         en;
		bit           typed;
		line_result_t res;
	} directed_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_data      = 1'b0;

	always #1 clk = ~clk;

	gcode_mcode_line_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// parser model state
	phase_t             ph;
	logic [CodeW-1:0]   acc;
	logic               sw_pend;
	logic [StatusW-1:0] dec;
	logic               echo_q;
	logic               light_q;
	logic               light_en;

	line_result_t  line_status_q[$];
	directed_row_t dir_rows[$];
	logic [7:0]    line_buf[$];
	int            errors = 0;
	int            cycles = 0;
	int            burst_left = 0;
	line_result_t  got, want;

	function automatic void clear_line();
		ph      = PH_LEAD;
		acc     = '0;
		sw_pend = 1'b0;
		dec     = ST_OK;
	endfunction

	function automatic void close_line(input logic [StatusW-1:0] st);
		dec = st;
		ph  = PH_DONE;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// returns 1 when the same character has to be looked at again
	function automatic bit parse_char(input logic [7:0] c);
		bit redo;
		redo = 1'b0;
		case (ph)
			PH_LEAD: begin
				if (c == CH_M)
					ph = PH_DIGITS;
				else if (c == CH_G)
					close_line(ST_G_UNSUP);
				else if (c != CH_SPACE)
					close_line(ST_NO_CODE);
			end
			PH_DIGITS: begin
				if (is_digit(c)) begin
					acc = acc * 16'd10 + (c - CH_ZERO);
				end else if (acc == CODE_ECHO) begin
					ph   = PH_ECHO_SPC;
					redo = 1'b1;
				end else if (acc == CODE_LIGHT && light_en) begin
					ph   = PH_LIGHT_SPC;
					redo = 1'b1;
				end else begin
					close_line(ST_M_UNSUP);
				end
			end
			PH_ECHO_SPC: begin
				if (c == CH_S)
					ph = PH_ECHO_VAL;
				else if (c != CH_SPACE)
					close_line(ST_S_MISSING);
			end
			PH_ECHO_VAL: begin
				echo_q = (c == CH_ONE);
				close_line(ST_OK);
			end
			PH_LIGHT_SPC: begin
				if (c == CH_S)
					ph = PH_LIGHT_VAL;
				else if (c != CH_SPACE)
					close_line(ST_S_MISSING);
			end
			PH_LIGHT_VAL: begin
				sw_pend = (c == CH_ONE);
				ph      = PH_LIGHT_NUM;
				redo    = 1'b1;
			end
			PH_LIGHT_NUM: begin
				if (!is_digit(c)) begin
					ph   = PH_LIGHT_GAP;
					redo = 1'b1;
				end
			end
			PH_LIGHT_GAP: begin
				if (c == CH_P) begin
					light_q = sw_pend;
					close_line(ST_OK);
				end else if (c != CH_SPACE) begin
					close_line(ST_P_MISSING);
				end
			end
			default: ph = PH_DONE;
		endcase
		return redo;
	endfunction

	function automatic void feed_char(input logic [7:0] c);
		int guard;
		guard = 0;
		while (parse_char(c) && guard < 8)
			guard++;
	endfunction

	// one character item in; returns 1 with the line status on the last one
	function automatic bit predict_line_status(input logic [7:0] c, input logic last,
			output line_result_t r);
		r = '0;
		feed_char(c);
		if (!last)
			return 1'b0;
		// line end behaves like a non-matching character
		if (ph != PH_DONE)
			feed_char(CH_NUL);
		if (ph != PH_DONE)
			close_line(ST_NO_CODE);
		r.status   = dec;
		r.mcode    = (dec == ST_NO_CODE || dec == ST_G_UNSUP) ? '0 : acc;
		r.echo_on  = echo_q;
		r.light_on = light_q;
		clear_line();
		return 1'b1;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
			input line_result_t typed_res);
		line_result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (predict_line_status(c, last, r))
			line_status_q.push_back(typed ? typed_res : r);
	endtask

	// called in the step of the last accepted item only
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (line_status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_light_enable(input logic v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		light_en = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input string text, input logic en, input bit typed,
			input logic [StatusW-1:0] st, input logic [CodeW-1:0] code,
			input logic echo, input logic light);
		directed_row_t row;
		row.text  = text;
		row.en    = en;
		row.typed = typed;
		row.res   = '{light_on: light, echo_on: echo, mcode: code, status: st};
		dir_rows.push_back(row);
	endtask

	function automatic logic [7:0] pick_char();
		string set;
		set = " MSPG0123456789";
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom_range(0, 255));
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic void put_spaces(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) line_buf.push_back(CH_SPACE);
	endfunction

	function automatic void put_decimal(input int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic void put_digits(input int n);
		repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void put_junk(input int n);
		repeat ($urandom_range(0, n)) line_buf.push_back(pick_char());
	endfunction

	function automatic void put_maybe(input logic [7:0] c);
		line_buf.push_back(($urandom_range(0, 7) == 0) ? pick_char() : c);
	endfunction

	// mostly well-formed echo and light lines with random detail, some noise
	function automatic void build_line();
		int kind;
		int sel;
		int keep;
		int unsigned near_codes[6];
		near_codes = '{65535, 65536, 65647, 65891, 111, 355};
		line_buf.delete();
		kind = $urandom_range(0, 15);
		if ($urandom_range(0, 2) == 0)
			put_spaces(1, 3);
		if (kind <= 3) begin
			line_buf.push_back(CH_M);
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back(CH_ZERO);
			put_decimal(111);
			put_spaces(0, 2);
			put_maybe(CH_S);
			sel = $urandom_range(0, 3);
			line_buf.push_back(sel <= 1 ? CH_ONE : (sel == 2 ? CH_ZERO : pick_char()));
			put_junk(3);
		end else if (kind <= 8) begin
			line_buf.push_back(CH_M);
			put_decimal(355);
			put_spaces(0, 2);
			put_maybe(CH_S);
			sel = $urandom_range(0, 3);
			line_buf.push_back(sel <= 1 ? CH_ONE : (sel == 2 ? CH_ZERO : pick_char()));
			put_digits($urandom_range(0, 3));
			put_spaces(0, 2);
			put_maybe(CH_P);
			put_junk(2);
		end else if (kind <= 10) begin
			line_buf.push_back(CH_M);
			sel = $urandom_range(0, 2);
			if (sel == 0)
				put_decimal($urandom_range(0, 999));
			else if (sel == 1)
				put_digits($urandom_range(1, 8));
			put_junk(3);
		end else if (kind == 11) begin
			line_buf.push_back(CH_G);
			put_digits($urandom_range(0, 3));
			put_junk(3);
		end else if (kind == 12) begin
			line_buf.push_back(CH_M);
			put_decimal(near_codes[$urandom_range(0, 5)]);
			put_junk(4);
		end else begin
			put_junk(8);
		end
		// cut some lines short
		if ($urandom_range(0, 7) == 0 && line_buf.size() > 1) begin
			keep = $urandom_range(1, line_buf.size() - 1);
			while (line_buf.size() > keep)
				void'(line_buf.pop_back());
		end
		if (line_buf.size() == 0)
			line_buf.push_back(pick_char());
	endfunction

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	// sink: stall patterns of its own, with one long hold-off
	initial begin
		int rx_cycles;
		int mode;
		int mode_left;
		bit held;
		rx_cycles = 0;
		mode      = 0;
		mode_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			// hold off once a result waits while the source is still offering
			if (!held && rx_cycles >= HOLD_AT && s_axis_tvalid && m_axis_tvalid) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= rx_cycles[2];
				endcase
			end
		end
	end

	// output checker
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got = line_result_t'(m_axis_tdata[20:0]);
			if (line_status_q.size() == 0) begin
				note_error($sformatf("unexpected item: status %0d mcode %0d echo %0b light %0b",
					got.status, got.mcode, got.echo_on, got.light_on));
			end else begin
				want = line_status_q.pop_front();
				if (got.status !== want.status || got.mcode !== want.mcode ||
						got.echo_on !== want.echo_on || got.light_on !== want.light_on)
					note_error($sformatf({"mismatch: exp status %0d mcode %0d echo %0b light %0b,",
						" got status %0d mcode %0d echo %0b light %0b"},
						want.status, want.mcode, want.echo_on, want.light_on,
						got.status, got.mcode, got.echo_on, got.light_on));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[gcode_mcode_line_parser_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [7:0] c;
		int len;
		int sent;
		logic phase_en[4];
		phase_en = '{1'b1, 1'b0, 1'b1, 1'b0};
		light_en = 1'b1;
		echo_q   = 1'b0;
		light_q  = 1'b0;
		clear_line();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flags are known here: nothing set them yet, until the echo rows
		add_row("G1",          1'b1, 1, ST_G_UNSUP,   16'd0,     1'b0, 1'b0);
		add_row("X",           1'b1, 1, ST_NO_CODE,   16'd0,     1'b0, 1'b0);
		add_row("  M",         1'b1, 1, ST_M_UNSUP,   16'd0,     1'b0, 1'b0);
		add_row(" ",           1'b1, 1, ST_NO_CODE,   16'd0,     1'b0, 1'b0);
		add_row("M111",        1'b1, 1, ST_S_MISSING, CODE_ECHO,  1'b0, 1'b0);
		add_row("M355",        1'b1, 1, ST_S_MISSING, CODE_LIGHT, 1'b0, 1'b0);
		add_row("M355 S1",     1'b1, 1, ST_P_MISSING, CODE_LIGHT, 1'b0, 1'b0);
		add_row("M65535",      1'b1, 1, ST_M_UNSUP,   16'd65535, 1'b0, 1'b0);
		add_row("M65536",      1'b1, 1, ST_M_UNSUP,   16'd0,     1'b0, 1'b0);
		add_row("M111 S",      1'b1, 1, ST_OK,        CODE_ECHO,  1'b0, 1'b0);
		add_row("M111S1",      1'b1, 1, ST_OK,        CODE_ECHO,  1'b1, 1'b0);
		add_row("M355 S1 P",   1'b1, 1, ST_OK,        CODE_LIGHT, 1'b1, 1'b1);
		add_row("M355S0P",     1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M355 S123  P", 1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M111 S0 xyz", 1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M_",          1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("_",           1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("\377",        1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M9999999",    1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M355 S1 X",   1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M355 S0 P",   1'b0, 0, ST_OK, 16'd0, 1'b0, 1'b0);
		add_row("M355 S0 P",   1'b1, 0, ST_OK, 16'd0, 1'b0, 1'b0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].en != light_en)
				set_light_enable(dir_rows[i].en);
			len = dir_rows[i].text.len();
			for (int j = 0; j < len; j++) begin
				c = dir_rows[i].text[j];
				if (c == NUL_MARK)
					c = CH_NUL;
				send_char(c, j == len - 1, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		sent = 0;
		for (int p = 0; p < 4; p++) begin
			set_light_enable(phase_en[p]);
			while (sent < (p + 1) * RANDOM_ITEMS / 4) begin
				build_line();
				foreach (line_buf[k])
					send_char(line_buf[k], k == line_buf.size() - 1, 0, '0);
				sent += line_buf.size();
			end
		end

		wait_drained();
		if (errors == 0 && line_status_q.size() == 0) begin
			$display("[gcode_mcode_line_parser_unit] OK");
		end else begin
			$display("[gcode_mcode_line_parser_unit] ERROR");
		end
		$finish;
	end

endmodule
